// ----- src/rpnc_pkg.sv -----
// ----------------------------------------------------------------------------
// rpnc_pkg
// Shared types, codes and sizes of the RPN calculator core.
// ----------------------------------------------------------------------------
`default_nettype none
package rpnc_pkg;
   localparam int STACK_DEPTH = 64;
   localparam int VAR_COUNT   = 26;
   localparam int SP_W        = $clog2(STACK_DEPTH + 1);
   localparam int SA_W        = $clog2(STACK_DEPTH);
   localparam int VA_W        = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
   localparam int TAG_W       = 6;

   localparam logic [3:0] F_NUM = 4'd0, F_VAR = 4'd1, F_ADD = 4'd2, F_SUB = 4'd3,
      F_MUL = 4'd4, F_DIV = 4'd5, F_MOD = 4'd6, F_SHOW = 4'd7, F_DUP = 4'd8,
      F_SWAP = 4'd9, F_CLR = 4'd10, F_STO = 4'd11, F_RCL = 4'd12, F_EOL = 4'd13;

   localparam logic [1:0] K_LINE = 2'd0, K_SHOW = 2'd1, K_RCL = 2'd2, K_ERR = 2'd3;

   localparam logic [2:0] E_NONE = 3'd0, E_EMPTY = 3'd1, E_FULL = 3'd2,
      E_ZDIV = 3'd3, E_SWAP = 3'd4;

   // divider request and reply
   typedef struct packed {
      logic        start;
      logic        is_mod;
      logic [31:0] a;
      logic [31:0] b;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] result;
   } div_rsp_type;
endpackage
`default_nettype wire

// ----- src/rpn_stack_calculator_with_variables_core.sv -----
// ----------------------------------------------------------------------------
// rpn_stack_calculator_with_variables_core
// Reverse Polish calculator on parsed tokens with a tagged stack, variables
// and a last-result register. Q16.16 saturating arithmetic.
// ----------------------------------------------------------------------------
// Usage:
//  req_ channel carries one token per beat (func, literal_value, var_index).
//  rsp_ channel returns at most one report beat per token.
//  req_ready is low while a token is in work. Each token walks a small
//  sequencer over one stack RAM port (one read or write per cycle);
//  div/mod also wait on the radix-2 divider (rpnc_div) for their result.
//  The result sits in an output register; the next token is taken as soon
//  as the report beat is presented, even if rsp_ready stays low, but that
//  token's own report waits until the register is emptied.
//  Reset clears the pointer, variables (valid bits) and last result and
//  sets the line flag; stack RAM contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module rpn_stack_calculator_with_variables_core
   import rpnc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [3:0]  req_func,
   input  wire logic signed [31:0] req_literal_value,
   input  wire logic [4:0]  req_var_index,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_report_kind,
   output logic signed [31:0] rsp_report_value,
   output logic [2:0]       rsp_error_code
);
   localparam logic [3:0] S_IDLE = 4'd0, S_POPB = 4'd1, S_RB = 4'd2, S_POPA = 4'd3,
      S_RA = 4'd4, S_EXEC = 4'd5, S_WAITD = 4'd6, S_PUSH = 4'd7, S_RTOP = 4'd8,
      S_RTOP2 = 4'd9, S_SWW1 = 4'd10, S_SWW2 = 4'd11, S_FIN = 4'd12,
      S_RESV = 4'd13;

   logic [3:0] state_ff, state_in;

   // stack RAM: one port, registered read
   logic [TAG_W+31:0] stk_mem [STACK_DEPTH];
   logic [TAG_W+31:0] rd_ff;
   logic              we;
   logic [SA_W-1:0]   addr;
   logic [TAG_W+31:0] wdata;

   always_ff @(posedge clock) begin
      if (we) stk_mem[addr] <= wdata;
      rd_ff <= stk_mem[addr];
   end

   logic [31:0] vars_ff [VAR_COUNT];
   logic [VAR_COUNT-1:0] vval_ff;
   logic [31:0] last_ff;
   logic        plain_ff, plain_in;
   logic [SP_W-1:0] sp_ff, sp_in;
   logic [3:0]  fn_ff, fn_in;
   logic [2:0]  err_ff, err_in;
   logic [31:0] a_ff, a_in, b_ff, b_in;
   logic [TAG_W-1:0] t_ff, t_in;        // tag of popped entry
   logic [TAG_W+31:0] hold_ff, hold_in; // entry held for swap
   logic [TAG_W+31:0] pw_ff, pw_in;     // entry to push
   logic        rep_ff, rep_in;
   logic [1:0]  kind_ff, kind_in;
   logic [31:0] rv_ff, rv_in;
   logic        ov_ff, ov_in;
   logic [1:0]  ok_ff, ok_in;
   logic [31:0] ovl_ff, ovl_in;
   logic [2:0]  oe_ff, oe_in;
   logic        mw_in;                  // load the multiply stage
   logic signed [63:0] prod_ff;
   logic        vwe;
   logic [4:0]  vwi;
   logic [31:0] vwd;
   div_req_type dreq;
   div_rsp_type drsp;

   rpnc_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   function automatic logic [31:0] vread(input logic [4:0] i,
         input logic [31:0] v [VAR_COUNT], input logic [VAR_COUNT-1:0] ok,
         input logic [31:0] lr);
      logic [31:0] x;
      x = lr;
      if (32'(i) < VAR_COUNT) x = ok[i[VA_W-1:0]] ? v[i[VA_W-1:0]] : 32'd0;
      return x;
   endfunction

   function automatic logic [31:0] sat33(input logic [32:0] s);
      logic [31:0] x;
      x = s[31:0];
      if (s[32] != s[31]) x = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      return x;
   endfunction

   logic [31:0] resolved;
   logic signed [47:0] mq;
   assign resolved = rd_ff[TAG_W+31] ? vread(rd_ff[TAG_W+30:32], vars_ff, vval_ff, last_ff)
                                     : rd_ff[31:0];
   assign mq = prod_ff[63:16];

   always_comb begin
      state_in = state_ff; sp_in = sp_ff; plain_in = plain_ff;
      fn_in = fn_ff; err_in = err_ff;
      a_in = a_ff; b_in = b_ff; t_in = t_ff; hold_in = hold_ff; pw_in = pw_ff;
      rep_in = rep_ff; kind_in = kind_ff; rv_in = rv_ff;
      ov_in = ov_ff; ok_in = ok_ff; ovl_in = ovl_ff; oe_in = oe_ff; mw_in = 1'b0;
      we = 1'b0; addr = sp_ff[SA_W-1:0]; wdata = pw_ff;
      vwe = 1'b0; vwi = '0; vwd = '0;
      dreq = '0; dreq.a = a_ff; dreq.b = b_ff; dreq.is_mod = (fn_ff == F_MOD);
      req_ready = 1'b0;
      if (ov_ff && rsp_ready) ov_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               fn_in = req_func;
               err_in = E_NONE; rep_in = 1'b0; kind_in = K_ERR; rv_in = '0;
               a_in = '0; b_in = '0; t_in = '0;
               priority case (req_func)
                  F_NUM: begin pw_in = {6'd0, req_literal_value}; state_in = S_PUSH; end
                  F_VAR: begin pw_in = {1'b1, req_var_index, 32'd0}; state_in = S_PUSH; end
                  F_ADD, F_SUB, F_MUL, F_DIV, F_MOD: state_in = S_POPB;
                  F_SHOW, F_DUP: begin plain_in = 1'b0; state_in = S_RTOP; end
                  F_SWAP: begin plain_in = 1'b0; state_in = S_RTOP; end
                  F_CLR: begin plain_in = 1'b0; sp_in = '0; state_in = S_FIN; end
                  F_STO, F_RCL: begin plain_in = 1'b0; state_in = S_POPB; end
                  F_EOL: begin
                     plain_in = 1'b1;
                     state_in = plain_ff ? S_POPB : S_FIN;
                  end
                  default: state_in = S_FIN;
               endcase
            end
         end
         // pop into b or a (b also gives the tag for store/recall)
         S_POPB, S_POPA: begin
            if (sp_ff == '0) begin
               if (err_ff == E_NONE) err_in = E_EMPTY;
               if (state_ff == S_POPB) begin
                  b_in = '0; t_in = '0;
                  priority if (fn_ff == F_RCL) state_in = S_FIN;
                  else if (fn_ff == F_STO) state_in = S_POPA;
                  else if (fn_ff == F_EOL) begin
                     a_in = '0; state_in = S_EXEC;
                  end else if (fn_ff == F_MOD) state_in = S_EXEC;
                  else state_in = S_POPA;
               end else begin
                  a_in = '0; state_in = S_EXEC;
               end
            end else begin
               sp_in = sp_ff - 1'b1;
               addr = sp_in[SA_W-1:0];
               state_in = (state_ff == S_POPB) ? S_RB : S_RA;
            end
         end
         S_RB: begin
            b_in = resolved; t_in = rd_ff[TAG_W+31:32];
            priority if (fn_ff == F_RCL) begin
               rep_in = 1'b1; kind_in = K_RCL;
               rv_in = vread(rd_ff[TAG_W+31] ? rd_ff[TAG_W+30:32] : 5'd0,
                             vars_ff, vval_ff, last_ff);
               state_in = S_FIN;
            end else if (fn_ff == F_STO) state_in = S_POPA;
            else if (fn_ff == F_EOL) begin a_in = resolved; state_in = S_EXEC; end
            else if (fn_ff == F_MOD && resolved == '0) begin
               if (err_ff == E_NONE) err_in = E_ZDIV;
               state_in = S_FIN;
            end else state_in = S_POPA;
         end
         S_RA: begin a_in = resolved; state_in = S_EXEC; end
         S_EXEC: begin
            pw_in[TAG_W+31:32] = '0;
            unique case (fn_ff)
               F_ADD: begin
                  pw_in[31:0] = sat33({a_ff[31], a_ff} + {b_ff[31], b_ff});
                  state_in = S_PUSH;
               end
               F_SUB: begin
                  pw_in[31:0] = sat33({a_ff[31], a_ff} - {b_ff[31], b_ff});
                  state_in = S_PUSH;
               end
               F_MUL: begin mw_in = 1'b1; state_in = S_RESV; end
               F_DIV, F_MOD: begin
                  if (b_ff == '0) begin
                     if (err_ff == E_NONE) err_in = E_ZDIV;
                     state_in = S_FIN;
                  end else begin
                     dreq.start = 1'b1; state_in = S_WAITD;
                  end
               end
               F_STO: begin
                  vwe = 1'b1; vwd = a_ff;
                  vwi = t_ff[5] ? t_ff[4:0] : 5'd0;
                  state_in = S_FIN;
               end
               F_EOL: begin
                  vwe = 1'b1; vwi = 5'd31; vwd = a_ff;
                  rep_in = 1'b1; kind_in = K_LINE; rv_in = a_ff;
                  state_in = S_FIN;
               end
               default: state_in = S_FIN;
            endcase
         end
         S_RESV: begin
            if (mq > 48'sh7FFF_FFFF) pw_in[31:0] = 32'h7FFF_FFFF;
            else if (mq < -48'sh8000_0000) pw_in[31:0] = 32'h8000_0000;
            else pw_in[31:0] = mq[31:0];
            state_in = S_PUSH;
         end
         S_WAITD: if (drsp.done) begin
            pw_in = {6'd0, drsp.result}; state_in = S_PUSH;
         end
         S_PUSH: begin
            if (32'(sp_ff) >= STACK_DEPTH) begin
               if (err_ff == E_NONE) err_in = E_FULL;
            end else begin
               we = 1'b1; sp_in = sp_ff + 1'b1;
            end
            state_in = S_FIN;
         end
         S_RTOP: begin
            if (sp_ff == '0 || (fn_ff == F_SWAP && sp_ff < SP_W'(2))) begin
               err_in = (fn_ff == F_SWAP) ? E_SWAP : E_EMPTY;
               state_in = S_FIN;
            end else begin
               addr = SA_W'(sp_ff - 1'b1);
               state_in = S_RTOP2;
            end
         end
         S_RTOP2: begin
            hold_in = rd_ff;
            priority if (fn_ff == F_SHOW) begin
               rep_in = 1'b1; kind_in = K_SHOW; rv_in = resolved; state_in = S_FIN;
            end else if (fn_ff == F_DUP) begin
               pw_in = rd_ff; state_in = S_PUSH;
            end else begin
               addr = SA_W'(sp_ff - SP_W'(2)); state_in = S_SWW1;
            end
         end
         S_SWW1: begin
            we = 1'b1; addr = SA_W'(sp_ff - 1'b1); wdata = rd_ff;
            state_in = S_SWW2;
         end
         S_SWW2: begin
            we = 1'b1; addr = SA_W'(sp_ff - SP_W'(2)); wdata = hold_ff;
            state_in = S_FIN;
         end
         S_FIN: if (!ov_in && (rep_ff || err_ff != E_NONE)) begin
            ov_in = 1'b1; oe_in = err_ff;
            ok_in = rep_ff ? kind_ff : K_ERR;
            ovl_in = rep_ff ? rv_ff : 32'd0;
            state_in = S_IDLE;
         end else if (!(rep_ff || err_ff != E_NONE)) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; sp_ff <= '0; plain_ff <= 1'b1; ov_ff <= 1'b0;
         vval_ff <= '0; last_ff <= '0;
      end else begin
         state_ff <= state_in; sp_ff <= sp_in; plain_ff <= plain_in; ov_ff <= ov_in;
         if (vwe) begin
            if (32'(vwi) < VAR_COUNT) vval_ff[vwi[VA_W-1:0]] <= 1'b1;
            else last_ff <= vwd;
         end
      end
      if (vwe && 32'(vwi) < VAR_COUNT) vars_ff[vwi[VA_W-1:0]] <= vwd;
      if (mw_in) prod_ff <= $signed(a_ff) * $signed(b_ff);
      fn_ff <= fn_in; err_ff <= err_in;
      a_ff <= a_in; b_ff <= b_in; t_ff <= t_in; hold_ff <= hold_in; pw_ff <= pw_in;
      rep_ff <= rep_in; kind_ff <= kind_in; rv_ff <= rv_in;
      ok_ff <= ok_in; ovl_ff <= ovl_in; oe_ff <= oe_in;
   end

   assign rsp_valid        = ov_ff;
   assign rsp_report_kind  = ok_ff;
   assign rsp_report_value = ovl_ff;
   assign rsp_error_code   = oe_ff;
endmodule
`default_nettype wire

// ----- src/rpnc_div.sv -----
// ----------------------------------------------------------------------------
// rpnc_div
// Radix-2 restoring divider: Q16.16 quotient with saturation, or remainder
// carrying the divisor's sign. One quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module rpnc_div
   import rpnc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_rsp_type      rsp
);
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [47:0] num_ff, num_in;      // dividend shifting into quotient
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic        neg_ff, neg_in, mod_ff, mod_in, bneg_ff, bneg_in;
   logic [31:0] res_ff, res_in;

   logic [32:0] trial;
   logic [31:0] abs_a, abs_b;
   logic [47:0] q;
   logic [31:0] r;
   logic signed [49:0] sq;

   always_comb begin
      abs_a = req.a[31] ? (~req.a + 32'd1) : req.a;
      abs_b = req.b[31] ? (~req.b + 32'd1) : req.b;
      trial = {rem_ff[31:0], num_ff[47]} - {1'b0, den_ff};
      busy_in = busy_ff; done_in = 1'b0; cnt_in = cnt_ff;
      num_in = num_ff; rem_in = rem_ff; den_in = den_ff;
      neg_in = neg_ff; mod_in = mod_ff; bneg_in = bneg_ff; res_in = res_ff;
      q = num_ff; r = rem_ff[31:0]; sq = '0;
      if (req.start) begin
         busy_in = 1'b1; cnt_in = 6'd0; rem_in = '0; den_in = abs_b;
         mod_in = req.is_mod; bneg_in = req.b[31];
         neg_in = req.a[31] ^ req.b[31];
         num_in = req.is_mod ? {abs_a, 16'd0} >> 16 : {abs_a, 16'd0};
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial; num_in = {num_ff[46:0], 1'b1};
         end else begin
            rem_in = {rem_ff[31:0], num_ff[47]}; num_in = {num_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd47) begin
            busy_in = 1'b0; done_in = 1'b1;
            q = num_in; r = rem_in[31:0];
            if (mod_ff)
               res_in = bneg_ff ? (~r + 32'd1) : r;
            else begin
               sq = neg_ff ? -$signed({2'b00, q}) : $signed({2'b00, q});
               if (sq > 50'sh0_7FFF_FFFF) res_in = 32'h7FFF_FFFF;
               else if (sq < -50'sh0_8000_0000) res_in = 32'h8000_0000;
               else res_in = sq[31:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      num_ff <= num_in; rem_ff <= rem_in; den_ff <= den_in;
      neg_ff <= neg_in; mod_ff <= mod_in; bneg_ff <= bneg_in; res_ff <= res_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = res_ff;
endmodule
`default_nettype wire

// ----- src/rpnc_checker.sv -----
// ----------------------------------------------------------------------------
// rpnc_checker
// Port-level checks of the calculator core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module rpnc_checker
   import rpnc_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_report_kind,
   input wire logic [31:0] rsp_report_value,
   input wire logic [2:0]  rsp_error_code
);
   // error-only beats carry a zero value and a real error
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_report_kind == K_ERR |-> rsp_report_value == 32'd0
         && rsp_error_code != E_NONE)
      else $error("error beat malformed");
   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_error_code <= E_SWAP)
      else $error("bad error code");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_report_value))
      else $error("stalled beat changed");
   // a token accept makes the block busy on the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after accept");
endmodule

bind rpn_stack_calculator_with_variables_core rpnc_checker u_chk (.*);
`default_nettype wire
